[rtl/htok_pkg.sv]
`timescale 1ns / 1ps

package htok_pkg;

    localparam int CFG_W             = 11;
    localparam int MAX_TOKEN_LEN_DEF = 1024;
    localparam int FIFO_DEPTH_DEF    = 4;
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef enum logic [2:0] {
        CC_SP,
        CC_CR,
        CC_LF,
        CC_COLON,
        CC_OTHER
    } t_char_class;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_METHOD  = 3'd1,
        KIND_URI     = 3'd2,
        KIND_VERSION = 3'd3,
        KIND_KEY     = 3'd4,
        KIND_VALUE   = 3'd5
    } t_kind;

    typedef enum logic [3:0] {
        ST_METHOD  = 4'd0,
        ST_URI_GAP = 4'd1,
        ST_URI     = 4'd2,
        ST_VER_GAP = 4'd3,
        ST_VERSION = 4'd4,
        ST_EOL     = 4'd5,
        ST_KEY     = 4'd6,
        ST_BLANK   = 4'd7,
        ST_VAL_GAP = 4'd8,
        ST_VALUE   = 4'd9,
        ST_DONE    = 4'd10,
        ST_ERROR   = 4'd11
    } t_state;

    // one classified byte, front to back
    typedef struct packed {
        logic [7:0]  data;
        t_char_class cls;
    } t_item;

endpackage

[rtl/htok_front.sv]
`timescale 1ns / 1ps

module htok_front
    import htok_pkg::*;
(
    input  logic       i_in_valid,
    input  logic [7:0] i_in_byte,
    input  logic       i_q_full,
    output logic       o_in_ready,
    output logic       o_push,
    output t_item      o_item
);

    t_char_class cls;

    always_comb begin
        unique case (i_in_byte)
            CH_SP, CH_TAB: cls = CC_SP;
            CH_CR:         cls = CC_CR;
            CH_LF:         cls = CC_LF;
            CH_COLON:      cls = CC_COLON;
            default:       cls = CC_OTHER;
        endcase
    end

    assign o_in_ready  = !i_q_full;
    assign o_push      = i_in_valid && !i_q_full;
    assign o_item.data = i_in_byte;
    assign o_item.cls  = cls;

endmodule

[rtl/htok_fifo.sv]
`timescale 1ns / 1ps

module htok_fifo
    import htok_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULLC = CNT_W'(DEPTH);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_full  = (r_count == FULLC);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue pop while empty");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULLC)
        else $error("queue count out of range");

endmodule

[rtl/htok_back.sv]
`timescale 1ns / 1ps

module htok_back
    import htok_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    input  logic             i_q_valid,
    input  t_item            i_q_item,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [7:0]       o_out_byte,
    output logic [2:0]       o_token_kind,
    output logic             o_token_byte,
    output logic             o_token_end,
    output logic             o_header_done,
    output logic             o_parse_error
);

    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam int LIM_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;
    localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_TOKEN_LEN);

    logic [CFG_W-1:0] r_max_len;
    t_state           r_state, n_state;
    logic [LEN_W-1:0] r_len, n_len;

    logic             r_out_valid;
    logic [7:0]       r_byte;
    t_kind            r_kind;
    logic             r_tbyte, r_tend, r_done, r_err;

    t_kind            kind, take_kind;
    logic             tbyte, tend, done, err, take;
    logic [LIM_W-1:0] lim, cfg_ext;
    logic [LEN_W-1:0] len_base;
    logic [LIM_W:0]   inc;
    logic             over, is_sp, is_eol, len_zero, in_gap;
    t_char_class      cls;

    assign cls      = i_q_item.cls;
    assign is_sp    = (cls == CC_SP);
    assign is_eol   = (cls == CC_CR) || (cls == CC_LF);
    assign len_zero = (r_len == '0);
    assign in_gap   = (r_state == ST_URI_GAP) || (r_state == ST_VER_GAP) ||
                      (r_state == ST_VAL_GAP);

    // limit in force is min(register, MAX_TOKEN_LEN); a token that starts
    // from a gap counts from zero
    assign cfg_ext  = LIM_W'(r_max_len);
    assign lim      = (cfg_ext > MAX_LIM) ? MAX_LIM : cfg_ext;
    assign len_base = in_gap ? '0 : r_len;
    assign inc      = {1'b0, LIM_W'(len_base)} + 1'b1;
    assign over     = inc > {1'b0, lim};

    assign o_pop = i_q_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        kind      = KIND_NONE;
        tbyte     = 1'b0;
        tend      = 1'b0;
        done      = 1'b0;
        err       = 1'b0;
        take      = 1'b0;
        take_kind = KIND_NONE;
        unique case (r_state)
            ST_METHOD, ST_URI: begin
                if (is_eol) begin
                    err = 1'b1;
                end else if (is_sp) begin
                    if (len_zero) begin
                        err = 1'b1;
                    end else begin
                        kind    = (r_state == ST_METHOD) ? KIND_METHOD : KIND_URI;
                        tend    = 1'b1;
                        n_len   = '0;
                        n_state = (r_state == ST_METHOD) ? ST_URI_GAP : ST_VER_GAP;
                    end
                end else begin
                    take      = 1'b1;
                    take_kind = (r_state == ST_METHOD) ? KIND_METHOD : KIND_URI;
                end
            end
            ST_URI_GAP, ST_VER_GAP: begin
                if (is_eol) begin
                    err = 1'b1;
                end else if (!is_sp) begin
                    take      = 1'b1;
                    take_kind = (r_state == ST_URI_GAP) ? KIND_URI : KIND_VERSION;
                    n_state   = (r_state == ST_URI_GAP) ? ST_URI : ST_VERSION;
                end
            end
            ST_VERSION, ST_VALUE: begin
                if (is_eol) begin
                    kind    = (r_state == ST_VERSION) ? KIND_VERSION : KIND_VALUE;
                    tend    = 1'b1;
                    n_len   = '0;
                    n_state = (cls == CC_CR) ? ST_EOL : ST_KEY;
                end else begin
                    take      = 1'b1;
                    take_kind = (r_state == ST_VERSION) ? KIND_VERSION : KIND_VALUE;
                end
            end
            ST_EOL: begin
                if (cls == CC_LF) begin
                    n_state = ST_KEY;
                    n_len   = '0;
                end else if (cls != CC_CR) begin
                    err = 1'b1;
                end
            end
            ST_KEY: begin
                if (len_zero && cls == CC_CR) begin
                    n_state = ST_BLANK;
                end else if (len_zero && cls == CC_LF) begin
                    done    = 1'b1;
                    n_state = ST_DONE;
                end else if (is_eol || is_sp) begin
                    err = 1'b1;
                end else if (cls == CC_COLON) begin
                    if (len_zero) begin
                        err = 1'b1;
                    end else begin
                        kind    = KIND_KEY;
                        tend    = 1'b1;
                        n_len   = '0;
                        n_state = ST_VAL_GAP;
                    end
                end else begin
                    take      = 1'b1;
                    take_kind = KIND_KEY;
                end
            end
            ST_BLANK: begin
                if (cls == CC_LF) begin
                    done    = 1'b1;
                    n_state = ST_DONE;
                end else if (cls != CC_CR) begin
                    err = 1'b1;
                end
            end
            ST_VAL_GAP: begin
                if (is_eol) begin
                    // empty value is legal
                    kind    = KIND_VALUE;
                    tend    = 1'b1;
                    n_len   = '0;
                    n_state = (cls == CC_CR) ? ST_EOL : ST_KEY;
                end else if (!is_sp) begin
                    take      = 1'b1;
                    take_kind = KIND_VALUE;
                    n_state   = ST_VALUE;
                end
            end
            ST_DONE: begin
            end
            ST_ERROR: begin
                err = 1'b1;
            end
            default: begin
                err = 1'b1;
            end
        endcase

        if (take) begin
            if (over) begin
                err = 1'b1;
            end else begin
                n_len = LEN_W'(inc);
                kind  = take_kind;
                tbyte = 1'b1;
            end
        end

        if (err) begin
            n_state = ST_ERROR;
            kind    = KIND_NONE;
            tbyte   = 1'b0;
            tend    = 1'b0;
            done    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len   <= CFG_RESET;
            r_state     <= ST_METHOD;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_len <= i_cfg_wr_data;
            end
            if (o_pop) begin
                r_state     <= n_state;
                r_len       <= n_len;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_byte  <= i_q_item.data;
            r_kind  <= kind;
            r_tbyte <= tbyte;
            r_tend  <= tend;
            r_done  <= done;
            r_err   <= (n_state == ST_ERROR);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_byte;
    assign o_token_kind  = r_kind;
    assign o_token_byte  = r_tbyte;
    assign o_token_end   = r_tend;
    assign o_header_done = r_done;
    assign o_parse_error = r_err;

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ERROR) |=> (r_state == ST_ERROR))
        else $error("parser left error state");

    a_len_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, LIM_W'(r_len)} <= {1'b0, MAX_LIM})
        else $error("token length beyond maximum");

    a_tbyte_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_tbyte) |-> (r_kind != KIND_NONE && !r_err && !r_done))
        else $error("token byte without a token kind");

    a_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && done) |=> (r_state == ST_DONE))
        else $error("header done without done state");

endmodule

[rtl/http_request_header_tokenizer_top.sv]
`timescale 1ns / 1ps

// HTTP/1.1 request header tokenizer.
// Input channel: one byte per request (i_in_valid / o_in_ready, i_in_byte).
// Output channel: one tagged byte per request (o_out_valid / i_out_ready):
//   the byte itself, token kind, token byte / token end marks, header done
//   on the LF of the blank line, and a parse error flag that holds until reset.
// Config: i_cfg_wr_en writes max_token_length (limit is the smaller of it and
//   MAX_TOKEN_LEN); write it only while the block is idle.
// Front end classifies each byte and pushes it into a FIFO_DEPTH-entry queue;
//   the back end runs the parser state machine and fills the output register.
// Path: the queue registers an accepted byte, then the parser pops it into
//   the output register, which holds it while the receiver stalls.
// Throughput: one byte per cycle while the receiver keeps i_out_ready high.
// Reset (synchronous, active low): parser waits for the method, token length
//   clears, the limit register returns to 1024, queue and output empty.
// When the receiver stalls, the held output register and then the queue
//   absorb bytes; o_in_ready drops once the queue is full.

module http_request_header_tokenizer_top
    import htok_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
    parameter int FIFO_DEPTH    = FIFO_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [7:0]       i_in_byte,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [7:0]       o_out_byte,
    output logic [2:0]       o_token_kind,
    output logic             o_token_byte,
    output logic             o_token_end,
    output logic             o_header_done,
    output logic             o_parse_error
);

    t_item push_item, head_item;
    logic  push, pop, q_full, q_valid;

    // byte classification and input handshake
    htok_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_byte  (i_in_byte),
        .i_q_full   (q_full),
        .o_in_ready (o_in_ready),
        .o_push     (push),
        .o_item     (push_item)
    );

    // decoupling queue
    htok_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (head_item)
    );

    // parser state machine and output register
    htok_back #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_valid     (q_valid),
        .i_q_item      (head_item),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_token_kind  (o_token_kind),
        .o_token_byte  (o_token_byte),
        .o_token_end   (o_token_end),
        .o_header_done (o_header_done),
        .o_parse_error (o_parse_error)
    );

endmodule

[tb/http_request_header_tokenizer_top_tb.sv]
`timescale 1ns / 1ps

// Byte-stream test of the request header tokenizer.
// A class predicts the tag of every accepted byte and checks the tagged
// bytes as they leave the block, in order. Parse errors stick and reset is
// applied only once, so the stream stays well formed (random request content
// over several token-limit settings) and one random ending follows: a blank
// line, or one of the header-line errors, then 20 random bytes.
module http_request_header_tokenizer_top_tb
    import htok_pkg::*;
();

    localparam int ITEMS = 1900;

    // Prediction and ordered checking of the tagged byte stream.
    class tokenizer_scoreboard;
        typedef struct packed {
            logic [7:0] data;
            t_kind      kind;
            logic       tbyte;
            logic       tend;
            logic       done;
            logic       err;
        } tag_t;

        t_state           st;
        logic [CFG_W-1:0] tok_len;
        logic [CFG_W-1:0] limit;
        tag_t             tags_due[$];
        int unsigned      fails;
        int unsigned      checked;

        function new();
            st      = ST_METHOD;
            tok_len = '0;
            limit   = CFG_RESET;
            fails   = 0;
            checked = 0;
        endfunction

        function void set_limit(logic [CFG_W-1:0] v);
            limit = (v > MAX_TOKEN_LEN_DEF) ? CFG_W'(MAX_TOKEN_LEN_DEF) : v;
        endfunction

        function int unsigned pending();
            return tags_due.size();
        endfunction

        task report(string what);
            fails++;
            $display("ERROR result %0d: %s", checked, what);
        endtask

        // length check comes before the byte joins the token
        function void grow(inout tag_t t, input t_kind k);
            if (tok_len + 1 > limit) begin
                st = ST_ERROR;
            end else begin
                tok_len++;
                t.kind  = k;
                t.tbyte = 1'b1;
            end
        endfunction

        // CR or LF closing a token; CR still needs its LF
        function void close_line(inout tag_t t, input t_kind k, input logic [7:0] b);
            t.kind  = k;
            t.tend  = 1'b1;
            tok_len = '0;
            st      = (b == CH_CR) ? ST_EOL : ST_KEY;
        endfunction

        function tag_t tag_byte(logic [7:0] b);
            tag_t t;
            logic blank;
            logic eol;
            t.data  = b;
            t.kind  = KIND_NONE;
            t.tbyte = 1'b0;
            t.tend  = 1'b0;
            t.done  = 1'b0;
            t.err   = 1'b0;
            blank   = (b == CH_SP) || (b == CH_TAB);
            eol     = (b == CH_CR) || (b == CH_LF);
            case (st)
                ST_METHOD, ST_URI: begin
                    if (eol) begin
                        st = ST_ERROR;
                    end else if (blank) begin
                        if (tok_len == 0) begin
                            st = ST_ERROR;
                        end else begin
                            t.kind  = (st == ST_METHOD) ? KIND_METHOD : KIND_URI;
                            t.tend  = 1'b1;
                            tok_len = '0;
                            st      = (st == ST_METHOD) ? ST_URI_GAP : ST_VER_GAP;
                        end
                    end else begin
                        grow(t, (st == ST_METHOD) ? KIND_METHOD : KIND_URI);
                    end
                end
                ST_URI_GAP, ST_VER_GAP: begin
                    if (eol) begin
                        st = ST_ERROR;
                    end else if (!blank) begin
                        tok_len = '0;
                        if (st == ST_URI_GAP) begin
                            st = ST_URI;
                            grow(t, KIND_URI);
                        end else begin
                            st = ST_VERSION;
                            grow(t, KIND_VERSION);
                        end
                    end
                end
                ST_VERSION: begin
                    if (eol) close_line(t, KIND_VERSION, b);
                    else grow(t, KIND_VERSION);
                end
                ST_EOL: begin
                    if (b == CH_LF) begin
                        st      = ST_KEY;
                        tok_len = '0;
                    end else if (b != CH_CR) begin
                        st = ST_ERROR;
                    end
                end
                ST_KEY: begin
                    if (tok_len == 0 && b == CH_CR) begin
                        st = ST_BLANK;
                    end else if (tok_len == 0 && b == CH_LF) begin
                        t.done = 1'b1;
                        st     = ST_DONE;
                    end else if (eol || blank) begin
                        st = ST_ERROR;
                    end else if (b == CH_COLON) begin
                        if (tok_len == 0) begin
                            st = ST_ERROR;
                        end else begin
                            t.kind  = KIND_KEY;
                            t.tend  = 1'b1;
                            tok_len = '0;
                            st      = ST_VAL_GAP;
                        end
                    end else begin
                        grow(t, KIND_KEY);
                    end
                end
                ST_BLANK: begin
                    if (b == CH_LF) begin
                        t.done = 1'b1;
                        st     = ST_DONE;
                    end else if (b != CH_CR) begin
                        st = ST_ERROR;
                    end
                end
                ST_VAL_GAP: begin
                    if (eol) begin
                        close_line(t, KIND_VALUE, b);
                    end else if (!blank) begin
                        tok_len = '0;
                        st      = ST_VALUE;
                        grow(t, KIND_VALUE);
                    end
                end
                ST_VALUE: begin
                    if (eol) close_line(t, KIND_VALUE, b);
                    else grow(t, KIND_VALUE);
                end
                ST_DONE: begin
                end
                default: begin
                    st = ST_ERROR;
                end
            endcase
            // error byte and everything after it: only the flag is up
            if (st == ST_ERROR) begin
                t.kind  = KIND_NONE;
                t.tbyte = 1'b0;
                t.tend  = 1'b0;
                t.done  = 1'b0;
                t.err   = 1'b1;
            end
            return t;
        endfunction

        function void note_byte(logic [7:0] b);
            tags_due.push_back(tag_byte(b));
        endfunction

        task check_tag(logic [7:0] data, logic [2:0] kind, logic tbyte,
                       logic tend, logic done, logic err);
            tag_t want;
            if (tags_due.size() == 0) begin
                report($sformatf("unexpected byte %02h", data));
                return;
            end
            want = tags_due.pop_front();
            checked++;
            if (data !== want.data)
                report($sformatf("byte %02h, want %02h", data, want.data));
            if (kind !== want.kind)
                report($sformatf("kind %0d, want %0d (byte %02h)", kind, want.kind, data));
            if (tbyte !== want.tbyte)
                report($sformatf("token_byte %b, want %b (byte %02h)", tbyte, want.tbyte, data));
            if (tend !== want.tend)
                report($sformatf("token_end %b, want %b (byte %02h)", tend, want.tend, data));
            if (done !== want.done)
                report($sformatf("header_done %b, want %b (byte %02h)", done, want.done, data));
            if (err !== want.err)
                report($sformatf("parse_error %b, want %b (byte %02h)", err, want.err, data));
        endtask
    endclass

    // ------------------------------------------------------------------
    // DUT signals; the inputs are all known from time zero
    // ------------------------------------------------------------------
    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0] i_cfg_wr_data = '0;
    logic             i_in_valid    = 1'b0;
    logic             o_in_ready;
    logic [7:0]       i_in_byte     = 8'h00;
    logic             o_out_valid;
    logic             i_out_ready   = 1'b0;
    logic [7:0]       o_out_byte;
    logic [2:0]       o_token_kind;
    logic             o_token_byte;
    logic             o_token_end;
    logic             o_header_done;
    logic             o_parse_error;

    tokenizer_scoreboard sb = new();

    int unsigned      bytes_taken = 0;  // requests accepted on the input side
    int unsigned      bytes_sent  = 0;  // same count, kept by the sender
    logic [CFG_W-1:0] cur_limit   = CFG_RESET;
    bit               in_burst    = 1'b0;
    bit               out_burst   = 1'b0;
    bit               held_long   = 1'b0;

    always #6 i_clk = ~i_clk;

    http_request_header_tokenizer_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_byte     (i_in_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_token_kind  (o_token_kind),
        .o_token_byte  (o_token_byte),
        .o_token_end   (o_token_end),
        .o_header_done (o_header_done),
        .o_parse_error (o_parse_error)
    );

    // ------------------------------------------------------------------
    // Monitor: samples pre-edge values; all driving is nonblocking.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                sb.note_byte(i_in_byte);
                bytes_taken++;
            end
            if (o_out_valid && i_out_ready) begin
                sb.check_tag(o_out_byte, o_token_kind, o_token_byte, o_token_end,
                             o_header_done, o_parse_error);
            end
        end
    end

    // Mostly short gaps, a few long ones; none at all in burst stretches.
    function automatic int unsigned idle_len(bit burst);
        int unsigned r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random ready with one long hold-off once the stream is
    // underway, so the internal queue fills and o_in_ready drops.
    // ------------------------------------------------------------------
    initial begin
        int unsigned stall;
        @(posedge i_clk);
        forever begin
            if (!held_long && bytes_taken >= 400) begin
                held_long = 1'b1;
                i_out_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end else begin
                stall = idle_len(out_burst);
                if (stall != 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------
    // One request; valid stays up across back-to-back bytes.
    task automatic send_byte(logic [7:0] b);
        int unsigned gap;
        gap = idle_len(in_burst);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
    endtask

    // Limit write: only with nothing in flight.
    task automatic set_token_limit(logic [CFG_W-1:0] v);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        sb.set_limit(v);
        cur_limit = v;
        i_cfg_wr_en <= 1'b0;
    endtask

    // token byte (start, or body of a key): no blank, no line end, colon optional
    function automatic logic [7:0] word_char(bit colon_ok);
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF ||
               (!colon_ok && c == CH_COLON));
        return c;
    endfunction

    // version / value body byte: anything but a line end
    function automatic logic [7:0] text_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CH_CR || c == CH_LF);
        return c;
    endfunction

    // length up to the smaller of the limit and cap, now and then exactly at it
    function automatic int unsigned pick_len(int unsigned cap);
        int unsigned m;
        m = (cur_limit < cap) ? cur_limit : cap;
        if ($urandom_range(0, 7) == 0) return m;
        return $urandom_range(1, m);
    endfunction

    task automatic send_word(int unsigned len, bit colon_ok, bit text_body);
        send_byte(word_char(colon_ok));
        repeat (len - 1) send_byte(text_body ? text_char() : word_char(colon_ok));
    endtask

    task automatic send_blanks(int unsigned n);
        repeat (n) send_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
    endtask

    // CR* LF
    task automatic send_line_end();
        repeat ($urandom_range(0, 3)) send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    task automatic send_header_line(int unsigned value_len);
        send_word(pick_len(12), 1'b0, 1'b0);
        send_byte(CH_COLON);
        send_blanks($urandom_range(0, 3));
        if (value_len != 0) send_word(value_len, 1'b1, 1'b1);
        send_line_end();
    endtask

    // Closing sequence: blank line or one malformed header line.
    task automatic send_ending();
        case ($urandom_range(0, 7))
            0: begin
                send_byte(CH_CR);
                send_byte(CH_LF);
            end
            1: send_byte(CH_LF);
            2: begin  // blank inside a key
                send_word(pick_len(6), 1'b0, 1'b0);
                send_blanks(1);
            end
            3: begin  // line end inside a key
                send_word(pick_len(6), 1'b0, 1'b0);
                send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
            end
            4: send_byte(CH_COLON);  // empty key
            5: send_blanks(1);       // blank where a key should start
            6: begin  // bad line ending: CR then a stray byte
                send_word(pick_len(6), 1'b0, 1'b0);
                send_byte(CH_COLON);
                send_word(pick_len(6), 1'b1, 1'b1);
                send_byte(CH_CR);
                send_byte(text_char());
            end
            default: begin  // key one byte over the limit
                set_token_limit(CFG_W'($urandom_range(1, 8)));
                send_word(cur_limit + 1, 1'b0, 1'b0);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned phase;
        int unsigned lines;
        int unsigned waited;
        bit          long_value_sent;
        logic [CFG_W-1:0] lim;

        phase           = 0;
        long_value_sent = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: one-byte tokens at a limit of 1, tab and space gaps,
        // extreme byte values, an empty value closed by a bare LF.
        set_token_limit(1);
        send_byte(8'hFF);
        send_byte(CH_SP);
        send_byte(CH_TAB);
        send_byte(8'h00);
        send_byte(CH_TAB);
        send_byte(CH_SP);
        send_byte(8'h7F);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(8'h01);
        send_byte(CH_COLON);
        send_byte(CH_LF);
        // Value with inner blank and colon, exactly at a limit of 4, CR CR LF.
        set_token_limit(4);
        send_byte(8'h80);
        send_byte(CH_COLON);
        send_byte(CH_SP);
        send_byte(CH_TAB);
        send_byte(8'h61);
        send_byte(CH_SP);
        send_byte(CH_COLON);
        send_byte(8'hFE);
        send_byte(CH_CR);
        send_byte(CH_CR);
        send_byte(CH_LF);

        // Random header lines over a range of limits.
        while (bytes_sent < ITEMS) begin
            case (phase)
                0: lim = 2;
                1: lim = 1024;
                2: lim = 16;
                3: lim = 1;
                default: begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: lim = CFG_W'($urandom_range(1, 32));
                        5, 6, 7:       lim = CFG_W'($urandom_range(33, 1024));
                        8:             lim = 1;
                        default:       lim = 1024;
                    endcase
                end
            endcase
            in_burst  = ($urandom_range(0, 3) == 0);
            out_burst = ($urandom_range(0, 3) == 0);
            set_token_limit(lim);
            // one value right at the top limit: counter runs to full width
            if (lim == 1024 && !long_value_sent) begin
                long_value_sent = 1'b1;
                send_header_line(1024);
            end
            lines = $urandom_range(6, 25);
            repeat (lines) begin
                if (bytes_sent < ITEMS) begin
                    // about one value in four is empty
                    send_header_line(($urandom_range(0, 3) == 0) ? 0 : pick_len(20));
                end
            end
            phase++;
        end

        in_burst  = 1'b0;
        out_burst = 1'b0;
        send_ending();
        // bytes after the ending: sticky error or plain pass-through
        repeat (20) send_byte(8'($urandom_range(0, 255)));
        i_in_valid <= 1'b0;

        waited = 0;
        while (sb.pending() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));

        if (sb.fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #12_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
